// File: sv/shamh_pkg.sv
// ----------------------------------------------------------------------------
// shamh_pkg
// Shared constants, round constants and sigma functions for the hasher.
// ----------------------------------------------------------------------------
package shamh_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned WORDS   = 8;
   localparam int unsigned ROUNDS  = 64;
   localparam int unsigned FILL_W  = 6;
   localparam int unsigned LEN_W   = 64;

   // action codes carried on tuser
   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   localparam logic [7:0] PAD_MARK     = 8'h80;
   localparam logic [5:0] LEN_OFFSET   = 6'd56;
   localparam logic [5:0] LAST_BYTE    = 6'd63;
   localparam logic [3:0] LEN_BYTES    = 4'd8;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [WORDS-1:0] hash_type;

   localparam hash_type INIT_HASH = '{
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

// File: sv/sha256_message_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher_top
// Byte-wide SHA-256 hasher with one shared round unit and byte-serial padding.
// ----------------------------------------------------------------------------
// absorb: one byte per cycle while req_tready is high; the byte that fills a block
// starts 64 rounds on the single round unit and a fold into the hash, with req_tready low
// finish: accepted, then the padding bytes (9..72 bytes) are packed and each padded block
// compressed, then eight digest transactions, one per cycle while rsp_tready is high
// reset: synchronous, active high; restores the initial hash, zero length
module sha256_message_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero pad
   output logic        rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_OUT
   } state_type;

   state_type               state_ff, state_in;
   shamh_pkg::hash_type     hash_ff, hash_in;
   shamh_pkg::hash_type     v_ff, v_in;
   logic [511:0]            block_ff, block_in;
   logic [5:0]              fill_ff, fill_in;
   logic [63:0]             count_ff, count_in;
   logic [63:0]             len_ff, len_in;
   logic                    fin_ff, fin_in;
   logic                    mark_ff, mark_in;
   logic [3:0]              lcnt_ff, lcnt_in;
   logic [5:0]              rnd_ff, rnd_in;
   logic [2:0]              idx_ff, idx_in;

   logic                    byte_go;
   logic [7:0]              byte_val;
   shamh_pkg::word_type     w_cur, w_new, t1, t2;

   // schedule word and round terms
   always_comb begin
      w_cur = block_ff[511:480];
      w_new = block_ff[511:480] + shamh_pkg::sig0(block_ff[479:448])
            + block_ff[223:192] + shamh_pkg::sig1(block_ff[63:32]);
      t1 = v_ff[7] + shamh_pkg::bsig1(v_ff[4])
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + shamh_pkg::ROUND_K[rnd_ff] + w_cur;
      t2 = shamh_pkg::bsig0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      v_in     = v_ff;
      block_in = block_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      len_in   = len_ff;
      fin_in   = fin_ff;
      mark_in  = mark_ff;
      lcnt_in  = lcnt_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      byte_go  = 1'b0;
      byte_val = 8'h00;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == shamh_pkg::ACT_FINISH) begin
                  len_in   = count_ff;
                  fin_in   = 1'b1;
                  mark_in  = 1'b0;
                  lcnt_in  = 4'd0;
                  state_in = ST_PAD;
               end else begin
                  byte_go  = 1'b1;
                  byte_val = req_tdata;
                  count_in = count_ff + 64'd8;
               end
            end
         end
         ST_PAD: begin
            byte_go = 1'b1;
            priority if (!mark_ff) begin
               byte_val = shamh_pkg::PAD_MARK;
               mark_in  = 1'b1;
            end else if (lcnt_ff == 4'd0 && fill_ff != shamh_pkg::LEN_OFFSET) begin
               byte_val = 8'h00;
            end else begin
               byte_val = len_ff[63:56];
               len_in   = {len_ff[55:0], 8'h00};
               lcnt_in  = lcnt_ff + 4'd1;
            end
         end
         ST_ROUND: begin
            v_in     = {v_ff[6:0], t1 + t2};
            v_in[4]  = v_ff[3] + t1;
            block_in = {block_ff[479:0], w_new};
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == shamh_pkg::LAST_BYTE) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + v_ff[i];
            end
            priority if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (lcnt_ff == shamh_pkg::LEN_BYTES) begin
               idx_in   = 3'd0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               hash_in = {shamh_pkg::word_type'(0), hash_ff[7:1]};
               idx_in  = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  hash_in  = shamh_pkg::INIT_HASH;
                  count_in = 64'd0;
                  fin_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // shared byte packer: shift in big-endian, compress on full block
      if (byte_go) begin
         block_in = {block_ff[503:0], byte_val};
         fill_in  = fill_ff + 6'd1;
         if (fill_ff == shamh_pkg::LAST_BYTE) begin
            v_in     = hash_ff;
            rnd_in   = 6'd0;
            state_in = ST_ROUND;
         end
      end
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hash_ff  <= shamh_pkg::INIT_HASH;
         fill_ff  <= '0;
         count_ff <= '0;
         fin_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         lcnt_ff  <= '0;
         rnd_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         fin_ff   <= fin_in;
         mark_ff  <= mark_in;
         lcnt_ff  <= lcnt_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
      end
      v_ff     <= v_in;
      block_ff <= block_in;
      len_ff   <= len_in;
   end

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, idx_ff, hash_ff[0]};
   assign rsp_tlast  = (idx_ff == 3'd7);

endmodule

// File: verif/sha256_message_hasher_top_test.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher_top_test
// Streams byte messages and finish commands into the hasher, computes the
// expected SHA-256 digest words alongside, and checks every digest word.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top_test;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } hash_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } digest_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] digest_word, [34:32] word_index, zero pad
   logic        rsp_tlast;

   sha256_message_hasher_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   // predictor state
   logic [31:0] chain_hash [8];
   logic [31:0] msg_block [16];
   int unsigned fill_count;
   logic [63:0] bit_length;

   hash_req_type   pending_reqs [$];
   digest_rsp_type expected_digest [$];
   int             error_count = 0;
   int             send_idle_pct = 33;
   int             recv_idle_pct = 78;
   bit             hold_sender = 1'b0;

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one compression of the current block into the chaining hash
   task automatic compress_msg_block();
      logic [31:0] sched [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) sched[t] = msg_block[t];
      for (int t = 16; t < 64; t++) begin
         s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
         s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
      end
      for (int t = 0; t < 8; t++) v[t] = chain_hash[t];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shamh_pkg::ROUND_K[t] + sched[t];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int t = 0; t < 8; t++) chain_hash[t] += v[t];
   endtask

   task automatic load_byte(logic [7:0] b);
      int sh;
      sh = (3 - (fill_count % 4)) * 8;
      if (fill_count % 4 == 0) msg_block[fill_count/4] = 32'(b) << sh;
      else msg_block[fill_count/4] |= 32'(b) << sh;
      fill_count++;
      if (fill_count == 64) begin
         compress_msg_block();
         fill_count = 0;
      end
   endtask

   task automatic init_hash_state();
      for (int i = 0; i < 8; i++) chain_hash[i] = shamh_pkg::INIT_HASH[i];
      fill_count = 0;
      bit_length = '0;
   endtask

   // expected digest words for one accepted transaction
   task automatic predict_digest(hash_req_type r);
      logic [63:0] len;
      digest_rsp_type d;
      if (r.action == shamh_pkg::ACT_ABSORB) begin
         load_byte(r.data_byte);
         bit_length += 64'd8;
      end else begin
         len = bit_length;
         load_byte(shamh_pkg::PAD_MARK);
         while (fill_count != shamh_pkg::LEN_OFFSET) load_byte(8'h00);
         for (int i = 7; i >= 0; i--) load_byte(len[i*8 +: 8]);
         for (int i = 0; i < 8; i++) begin
            d.digest_word = chain_hash[i];
            d.word_index  = 3'(i);
            d.last        = (i == 7);
            expected_digest.push_back(d);
         end
         init_hash_state();
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      hash_req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= shamh_pkg::ACT_ABSORB;
         init_hash_state();
         for (int i = 0; i < 16; i++) msg_block[i] = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            r.action    = req_tuser;
            r.data_byte = req_tdata;
            predict_digest(r);
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_reqs.size() > 0 && !hold_sender
                && $urandom_range(99) >= send_idle_pct) begin
               r = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= r.data_byte;
               req_tuser  <= r.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      digest_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digest.size() == 0) begin
               report_mismatch("unexpected digest word", 64'(rsp_tdata), 64'd0);
            end else begin
               want = expected_digest.pop_front();
               if (rsp_tdata[31:0] !== want.digest_word)
                  report_mismatch("digest_word", 64'(rsp_tdata[31:0]),
                                  64'(want.digest_word));
               if (rsp_tdata[34:32] !== want.word_index)
                  report_mismatch("word_index", 64'(rsp_tdata[34:32]),
                                  64'(want.word_index));
               if (rsp_tlast !== want.last)
                  report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_byte(logic [7:0] b);
      hash_req_type r;
      r.action = shamh_pkg::ACT_ABSORB;
      r.data_byte = b;
      pending_reqs.push_back(r);
   endtask

   task automatic queue_finish();
      hash_req_type r;
      r.action = shamh_pkg::ACT_FINISH;
      r.data_byte = 8'($urandom);
      pending_reqs.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_tvalid || expected_digest.size() > 0)
         @(posedge clock);
   endtask

   // stimulus
   initial begin
      int n;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message, two finishes in a row, extreme bytes
      queue_finish();
      queue_finish();
      queue_byte(8'h00); queue_byte(8'hff); queue_byte(8'h61); queue_finish();
      for (int i = 0; i < 3; i++) queue_byte(8'(8'h61 + i));
      queue_finish();
      queue_byte(8'haa); queue_byte(8'h55); queue_finish();
      wait_drained();

      // length pressure: 55 (one block), 56 (extra block), 63, 64 (full block)
      for (int k = 0; k < 4; k++) begin
         n = (k == 0) ? 55 : (k == 1) ? 56 : (k == 2) ? 63 : 64;
         for (int i = 0; i < n; i++) queue_byte(8'($urandom));
         queue_finish();
      end
      wait_drained();

      // random messages in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 78 : 0;
         recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 33 : 0;
         for (int m = 0; m < 4; m++) begin
            n = $urandom_range(0, 7);
            for (int i = 0; i < n; i++) queue_byte(8'($urandom));
            queue_finish();
         end
         wait_drained();
      end

      // sender held back with a byte and a finish queued, then released and drained
      hold_sender = 1'b1;
      queue_byte(8'h3c); queue_finish();
      repeat (20) @(posedge clock);
      hold_sender = 1'b0;
      wait_drained();

      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("sha256_message_hasher_top_test: clean");
      end else begin
         $display("sha256_message_hasher_top_test: errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("sha256_message_hasher_top_test: errors");
      $finish;
   end

endmodule
